/* sv/frba_pkg.sv */
// shared types and constants of the frame ring buffer allocator
`default_nettype none
package frba_pkg;

	// field widths
	localparam int SIZE_W   = 25;
	localparam int OFFSET_W = 24;
	localparam int CMD_W    = 2;
	localparam int SLOT_W   = 2;
	localparam int STATUS_W = 2;

	// allocations are 16-byte granular
	localparam int ALIGN_BITS = 4;

	// ring size after reset
	localparam logic [SIZE_W-1:0] SIZE_RESET = 25'd65536;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_SWAP  = 2'd1,
		CMD_FREE  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_NO_SPACE   = 2'd2
	} status_t;

	// allocator counters
	typedef struct packed {
		logic [SIZE_W-1:0] write_offset;
		logic [SIZE_W-1:0] frame_usage;
		logic [SIZE_W-1:0] available;
	} ctr_t;

	// one result item
	typedef struct packed {
		logic [OFFSET_W-1:0] alloc_offset;
		status_t             status;
	} res_t;

endpackage
`default_nettype wire

/* sv/frba_exec.sv */
// command evaluation: next counters, slot write and result of one item
`default_nettype none
module frba_exec (
	input  wire logic [frba_pkg::CMD_W-1:0]  cmd,
	input  wire logic [frba_pkg::SIZE_W-1:0] alloc_size,
	input  wire logic                        slot_ok,
	input  wire logic [frba_pkg::SIZE_W-1:0] buffer_size,
	input  wire logic [frba_pkg::SIZE_W-1:0] rec_rdata,
	input  wire frba_pkg::ctr_t              ctr,
	output frba_pkg::ctr_t                   ctr_next,
	output logic                             rec_we,
	output frba_pkg::res_t                   res
);
	import frba_pkg::*;

	logic [SIZE_W:0]   end_sum;
	logic              wrap;
	logic [SIZE_W-1:0] tail;
	logic [SIZE_W:0]   use_sum;
	logic [SIZE_W+1:0] need;
	logic              fits;
	logic [SIZE_W-1:0] base;
	logic [SIZE_W:0]   base_end;
	logic [SIZE_W-1:0] swap_avail;
	logic [SIZE_W:0]   free_sum;
	logic [SIZE_W-1:0] free_avail;

	// allocate datapath: wrap decision, charged usage and fit check
	always_comb begin
		end_sum  = {1'b0, ctr.write_offset} + {1'b0, alloc_size};
		wrap     = end_sum >= {1'b0, buffer_size};
		tail     = (buffer_size >= ctr.write_offset) ?
			(buffer_size - ctr.write_offset) : '0;
		use_sum  = {1'b0, ctr.frame_usage} + (wrap ? {1'b0, tail} : '0);
		need     = {1'b0, use_sum} + {2'b00, alloc_size};
		fits     = need <= {2'b00, ctr.available};
		base     = wrap ? '0 : ctr.write_offset;
		base_end = {1'b0, base} + {1'b0, alloc_size};
	end

	// swap and free arithmetic, both saturating
	always_comb begin
		swap_avail = (ctr.available >= ctr.frame_usage) ?
			(ctr.available - ctr.frame_usage) : '0;
		free_sum   = {1'b0, ctr.available} + {1'b0, rec_rdata};
		free_avail = (free_sum > {1'b0, buffer_size}) ?
			buffer_size : free_sum[SIZE_W-1:0];
	end

	// command select
	always_comb begin
		ctr_next         = ctr;
		rec_we           = 1'b0;
		res.alloc_offset = '0;
		res.status       = ST_OK;
		case (cmd_t'(cmd))
			CMD_ALLOC: begin
				if (alloc_size[ALIGN_BITS-1:0] != '0) begin
					res.status = ST_MISALIGNED;
				end else if (!fits) begin
					res.status = ST_NO_SPACE;
				end else begin
					res.alloc_offset      = base[OFFSET_W-1:0];
					ctr_next.frame_usage  = need[SIZE_W-1:0];
					ctr_next.write_offset = base_end[SIZE_W-1:0];
				end
			end
			CMD_SWAP: begin
				if (slot_ok) begin
					rec_we               = 1'b1;
					ctr_next.available   = swap_avail;
					ctr_next.frame_usage = '0;
				end
			end
			CMD_FREE: begin
				if (slot_ok) begin
					ctr_next.available = free_avail;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* sv/frame_ring_buffer_allocator.sv */
// top level of the frame ring buffer allocator
//
//   port group         direction  qualifier     contents
//   command item       in         start & !busy cmd, alloc_size, frame_index
//   result item        out        done          alloc_offset, status, space_available
//   ring size register in         buffer_size_we buffer_size_wdata
//
// one item per cycle while busy is low; an accepted item passes the input register and then
// the result register, which shows its result, marked by done.
// the counters update in the same cycle as the result register, so a following item
// sees them without stall. busy is high only in the first cycle after reset.
// results cannot be held off; each stands on the ports for exactly one cycle.
`default_nettype none
module frame_ring_buffer_allocator #(
	parameter int FRAMES = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [frba_pkg::CMD_W-1:0]      cmd,
	input  wire logic [frba_pkg::SIZE_W-1:0]     alloc_size,
	input  wire logic [frba_pkg::SLOT_W-1:0]     frame_index,
	input  wire logic                            buffer_size_we,
	input  wire logic [frba_pkg::SIZE_W-1:0]     buffer_size_wdata,
	output logic                                 done,
	output logic [frba_pkg::OFFSET_W-1:0]        alloc_offset,
	output logic [frba_pkg::STATUS_W-1:0]        status,
	output logic [frba_pkg::SIZE_W-1:0]          space_available
);
	import frba_pkg::*;

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic                busy_q;
	logic                valid_s1;
	logic [CMD_W-1:0]    cmd_s1;
	logic [SIZE_W-1:0]   size_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [SIZE_W-1:0]   buffer_size_q;
	ctr_t                ctr_q;
	ctr_t                ctr_next;
	logic [SIZE_W-1:0]   rec_q [FRAMES];
	logic                slot_ok;
	logic [IDX_W-1:0]    slot_idx;
	logic                rec_we;
	res_t                res;
	logic                done_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [STATUS_W-1:0] status_q;
	logic [SIZE_W-1:0]   space_q;

	assign busy = busy_q;

	// one-cycle busy after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			cmd_s1  <= cmd;
			size_s1 <= alloc_size;
			slot_s1 <= frame_index;
		end
	end

	// slot decode
	assign slot_ok  = 32'(slot_s1) < FRAMES;
	assign slot_idx = IDX_W'(slot_s1);

	frba_exec u_exec (
		.cmd         (cmd_s1),
		.alloc_size  (size_s1),
		.slot_ok     (slot_ok),
		.buffer_size (buffer_size_q),
		.rec_rdata   (rec_q[slot_idx]),
		.ctr         (ctr_q),
		.ctr_next    (ctr_next),
		.rec_we      (rec_we),
		.res         (res)
	);

	// ring size register and counters; a size write restarts the counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q      <= SIZE_RESET;
			ctr_q.write_offset <= '0;
			ctr_q.frame_usage  <= '0;
			ctr_q.available    <= SIZE_RESET;
		end else if (buffer_size_we) begin
			buffer_size_q      <= buffer_size_wdata;
			ctr_q.write_offset <= '0;
			ctr_q.frame_usage  <= '0;
			ctr_q.available    <= buffer_size_wdata;
		end else if (valid_s1) begin
			ctr_q <= ctr_next;
		end
	end

	// per-frame recorded usage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAMES; i++) begin
				rec_q[i] <= '0;
			end
		end else if (valid_s1 && rec_we) begin
			rec_q[slot_idx] <= ctr_q.frame_usage;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			offset_q <= res.alloc_offset;
			status_q <= res.status;
			space_q  <= ctr_next.available;
		end
	end

	assign done            = done_q;
	assign alloc_offset    = offset_q;
	assign status          = status_q;
	assign space_available = space_q;

endmodule
`default_nettype wire

/* sv/frba_checker.sv */
// port-level checks of the frame ring buffer allocator and their binding
`default_nettype none
module frba_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic [frba_pkg::CMD_W-1:0]      cmd,
	input wire logic [frba_pkg::SIZE_W-1:0]     alloc_size,
	input wire logic                            done,
	input wire logic [frba_pkg::OFFSET_W-1:0]   alloc_offset,
	input wire logic [frba_pkg::STATUS_W-1:0]   status
);
	import frba_pkg::*;

	// every accepted item yields a result through the input and result registers
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item produced no result");

	// no result without an accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	// a refused allocation reports offset zero
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> alloc_offset == '0)
		else $error("refused allocation with nonzero offset");

	// misalignment is reported only for an allocate with a misaligned size
	a_misaligned: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_MISALIGNED) |->
			($past(cmd, 2) == CMD_ALLOC &&
			 $past(alloc_size[ALIGN_BITS-1:0], 2) != '0))
		else $error("misaligned status on a valid request");

	// other commands never report an error
	a_other_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(cmd, 2) != CMD_ALLOC) |-> (status == ST_OK && alloc_offset == '0))
		else $error("swap or free reported an error or offset");

endmodule

bind frame_ring_buffer_allocator frba_checker u_frba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.alloc_size   (alloc_size),
	.done         (done),
	.alloc_offset (alloc_offset),
	.status       (status)
);
`default_nettype wire

/* tb/testbench.sv */
// testbench for the frame ring buffer allocator: directed and random command items
`timescale 1ns / 1ps
module testbench;
	import frba_pkg::*;

	localparam int FRAMES = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int DRAIN_LIMIT = 1000;
	// cmd encoding the block has no operation for
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [OFFSET_W-1:0] offset;
		status_t             st;
		logic [SIZE_W-1:0]   space;
	} alloc_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    cmd;
	logic [SIZE_W-1:0]   alloc_size;
	logic [SLOT_W-1:0]   frame_index;
	logic                buffer_size_we;
	logic [SIZE_W-1:0]   buffer_size_wdata;
	logic                done;
	logic [OFFSET_W-1:0] alloc_offset;
	logic [STATUS_W-1:0] status;
	logic [SIZE_W-1:0]   space_available;

	// allocator state as the testbench tracks it
	logic [SIZE_W-1:0] ring_size_q;
	logic [SIZE_W-1:0] ring_offset;
	logic [SIZE_W-1:0] frame_bytes;
	logic [SIZE_W-1:0] avail_bytes;
	logic [SIZE_W-1:0] frame_record [FRAMES];

	alloc_result_t pending_results [$];
	int unsigned   mismatch_count;
	int unsigned   items_sent;
	int unsigned   sender_idle_pct;

	frame_ring_buffer_allocator #(
		.FRAMES(FRAMES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.alloc_size(alloc_size),
		.frame_index(frame_index),
		.buffer_size_we(buffer_size_we),
		.buffer_size_wdata(buffer_size_wdata),
		.done(done),
		.alloc_offset(alloc_offset),
		.status(status),
		.space_available(space_available)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// apply one command to the tracked state and return its result
	function automatic alloc_result_t apply_ring_command(input logic [CMD_W-1:0] op,
			input logic [SIZE_W-1:0] size, input logic [SLOT_W-1:0] slot);
		alloc_result_t     r;
		logic [SIZE_W:0]   sum;
		logic [SIZE_W+1:0] need;
		logic [SIZE_W-1:0] base;
		r.offset = '0;
		r.st = ST_OK;
		case (op)
			CMD_ALLOC: begin
				if (size[ALIGN_BITS-1:0] != '0) begin
					r.st = ST_MISALIGNED;
				end else begin
					base = ring_offset;
					need = {2'b00, frame_bytes};
					sum = {1'b0, base} + {1'b0, size};
					// reaching the end restarts at zero and charges the skipped tail
					if (sum >= {1'b0, ring_size_q}) begin
						if (ring_size_q >= base)
							need = need + {2'b00, ring_size_q - base};
						base = '0;
					end
					need = need + {2'b00, size};
					if (need > {2'b00, avail_bytes}) begin
						r.st = ST_NO_SPACE;
					end else begin
						r.offset = base[OFFSET_W-1:0];
						frame_bytes = need[SIZE_W-1:0];
						sum = {1'b0, base} + {1'b0, size};
						ring_offset = sum[SIZE_W-1:0];
					end
				end
			end
			CMD_SWAP: begin
				if (slot < FRAMES) begin
					frame_record[slot] = frame_bytes;
					avail_bytes = (avail_bytes >= frame_bytes) ? avail_bytes - frame_bytes : '0;
					frame_bytes = '0;
				end
			end
			CMD_FREE: begin
				if (slot < FRAMES) begin
					sum = {1'b0, avail_bytes} + {1'b0, frame_record[slot]};
					avail_bytes = (sum > {1'b0, ring_size_q}) ? ring_size_q : sum[SIZE_W-1:0];
				end
			end
			default: begin
			end
		endcase
		r.space = avail_bytes;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// compare each result item with the oldest expected one
	always @(posedge clk) begin : check_results
		alloc_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result item with none expected (offset %0h status %0d)",
					alloc_offset, status));
			end else begin
				want = pending_results.pop_front();
				if (alloc_offset !== want.offset)
					report_mismatch($sformatf("alloc_offset %0h, expected %0h",
						alloc_offset, want.offset));
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (space_available !== want.space)
					report_mismatch($sformatf("space_available %0h, expected %0h",
						space_available, want.space));
			end
		end
	end

	// send one item, with random idle cycles ahead of it
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [SIZE_W-1:0] size,
			input logic [SLOT_W-1:0] slot);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			cmd <= CMD_W'($urandom);
			alloc_size <= SIZE_W'($urandom);
			frame_index <= SLOT_W'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		alloc_size <= size;
		frame_index <= slot;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_results.push_back(apply_ring_command(op, size, slot));
		items_sent++;
	endtask

	// write the ring size once every result is back
	task automatic set_ring_size(input logic [SIZE_W-1:0] value);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		buffer_size_we <= 1'b1;
		buffer_size_wdata <= value;
		@(posedge clk);
		buffer_size_we <= 1'b0;
		buffer_size_wdata <= SIZE_W'($urandom);
		ring_size_q = value;
		avail_bytes = value;
		ring_offset = '0;
		frame_bytes = '0;
	endtask

	// allocations in the reset ring: alignment, plain grants and wraps
	task automatic test_alloc_and_wrap();
		send_item(CMD_ALLOC, 25'd0, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd1, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd15, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'h1FFFFFF, SLOT_W'($urandom));
		// wrap charge makes this one too big
		send_item(CMD_ALLOC, 25'd65520, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd65504, SLOT_W'($urandom));
		// offset plus size lands exactly on the end
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
	endtask

	// frame recording, release, repeated release and saturation
	task automatic test_swap_and_free();
		send_item(CMD_SWAP, SIZE_W'($urandom), 2'd0);
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd0, SLOT_W'($urandom));
		send_item(CMD_FREE, SIZE_W'($urandom), 2'd0);
		send_item(CMD_FREE, SIZE_W'($urandom), 2'd0);
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
		send_item(CMD_SWAP, SIZE_W'($urandom), 2'd3);
		send_item(CMD_FREE, SIZE_W'($urandom), 2'd1);
		send_item(CMD_FREE, SIZE_W'($urandom), 2'd3);
	endtask

	task automatic test_unused_command();
		send_item(CMD_UNUSED, SIZE_W'($urandom), SLOT_W'($urandom));
		send_item(CMD_UNUSED, 25'h1FFFFFF, 2'd3);
	endtask

	// zero ring: every request wraps, only size zero fits
	task automatic test_zero_ring();
		set_ring_size('0);
		send_item(CMD_ALLOC, 25'd0, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
		send_item(CMD_SWAP, SIZE_W'($urandom), 2'd2);
	endtask

	task automatic test_largest_ring();
		set_ring_size(25'h1000000);
		send_item(CMD_ALLOC, 25'h1000000, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'h0FFFFF0, SLOT_W'($urandom));
		send_item(CMD_FREE, SIZE_W'($urandom), 2'd2);
	endtask

	// offsets past 2^24 are reported in their low bits
	task automatic test_wide_offset();
		set_ring_size(25'h1FFFFFF);
		send_item(CMD_ALLOC, 25'h1000000, SLOT_W'($urandom));
		send_item(CMD_ALLOC, 25'd16, SLOT_W'($urandom));
	endtask

	// frames of allocations closed by a swap and release of the oldest slot,
	// mixed with misaligned, oversized, stray and unused items
	task automatic test_random_frames(input int unsigned idle_pct,
			input logic [SIZE_W-1:0] ring, input int unsigned n_items);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned slot_now;
		int unsigned unit_max;
		set_ring_size(ring);
		sender_idle_pct = idle_pct;
		stop_at = items_sent + n_items;
		slot_now = $urandom_range(FRAMES - 1);
		unit_max = 32'(ring) >> 6;
		while (items_sent < stop_at) begin
			repeat ($urandom_range(1, 6)) begin
				pick = $urandom_range(99);
				if (pick < 80)
					send_item(CMD_ALLOC, SIZE_W'($urandom_range(unit_max) << ALIGN_BITS),
						SLOT_W'($urandom));
				else if (pick < 88)
					send_item(CMD_ALLOC, SIZE_W'($urandom), SLOT_W'($urandom));
				else if (pick < 94)
					send_item(CMD_ALLOC, SIZE_W'($urandom & ~32'hF), SLOT_W'($urandom));
				else
					send_item(CMD_UNUSED, SIZE_W'($urandom), SLOT_W'($urandom));
			end
			pick = $urandom_range(99);
			if (pick < 85) begin
				send_item(CMD_SWAP, SIZE_W'($urandom), SLOT_W'(slot_now));
				send_item(CMD_FREE, SIZE_W'($urandom), SLOT_W'((slot_now + 1) % FRAMES));
			end else if (pick < 92) begin
				send_item(CMD_SWAP, SIZE_W'($urandom), SLOT_W'($urandom));
			end else begin
				send_item(CMD_FREE, SIZE_W'($urandom), SLOT_W'($urandom));
			end
			slot_now = (slot_now + 1) % FRAMES;
		end
	endtask

	initial begin
		int unsigned waited;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_ALLOC;
		alloc_size <= '0;
		frame_index <= '0;
		buffer_size_we <= 1'b0;
		buffer_size_wdata <= '0;
		mismatch_count = 0;
		items_sent = 0;
		sender_idle_pct = 27;
		ring_size_q = SIZE_RESET;
		avail_bytes = SIZE_RESET;
		ring_offset = '0;
		frame_bytes = '0;
		for (int i = 0; i < FRAMES; i++)
			frame_record[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_alloc_and_wrap();
		test_swap_and_free();
		test_unused_command();
		test_zero_ring();
		test_largest_ring();
		test_wide_offset();

		test_random_frames(27, 25'd4096, 65);
		test_random_frames(27, 25'd16, 65);
		test_random_frames(57, 25'h1000000, 65);
		test_random_frames(57, 25'd65536, 65);
		test_random_frames(0, SIZE_W'($urandom_range(16, 32'h100000)), 65);
		test_random_frames(0, 25'h100000, 65);

		// let the last results come back
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d expected result items never came",
				pending_results.size()));
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#400us;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
